### rtl/core/lz77c_pkg.sv
// Shared constants, payload types and controller/datapath interface types for the LZ77 encoder.
package lz77c_pkg;

  localparam int HIST_DEPTH = 64;
  localparam int MAX_MATCH  = 16;

  localparam int HCNT_W = $clog2(HIST_DEPTH + 1);
  localparam int LCNT_W = $clog2(MAX_MATCH + 1);
  localparam int LIDX_W = $clog2(MAX_MATCH);
  localparam int HIDX_W = $clog2(HIST_DEPTH);

  localparam int WIN_W  = 7;
  localparam int MINM_W = 5;
  localparam int OFF_W  = 7;
  localparam int LEN_W  = 5;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [0:0] REG_MIN_MATCH   = 1'b1;

  localparam logic [WIN_W-1:0]  WINDOW_SIZE_RST = 7'd64;
  localparam logic [MINM_W-1:0] MIN_MATCH_RST   = 5'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic             is_match;
    logic [7:0]       literal;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic             end_of_message;
  } token_t;

  typedef struct packed {
    logic push;
    logic start;
    logic step;
    logic decide;
    logic consume;
    logic clear;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic la_full;
    logic la_empty;
    logic search_done;
    logic consume_last;
  } dp_status_t;

endpackage

### rtl/core/lz77c_datapath.sv
// Datapath of the LZ77 encoder: lookahead, history shift line, compare cells and token register.
module lz77c_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  lz77c_pkg::dp_cmd_t              cmd,
  input  lz77c_pkg::item_t                item,
  input  logic [lz77c_pkg::WIN_W-1:0]     window_size,
  input  logic [lz77c_pkg::MINM_W-1:0]    min_match,
  output lz77c_pkg::dp_status_t           status,
  output lz77c_pkg::token_t               token
);
  import lz77c_pkg::*;

  logic [7:0]            la [MAX_MATCH];
  logic [LCNT_W-1:0]     la_cnt;
  logic [7:0]            hist [HIST_DEPTH];
  logic [HCNT_W-1:0]     hist_cnt;
  logic [7:0]            probe [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] alive;
  logic [LCNT_W-1:0]     k;
  logic [LCNT_W-1:0]     mlen;
  logic [LCNT_W-1:0]     rem;

  logic [HIST_DEPTH-1:0] eq;
  logic [HIST_DEPTH-1:0] alive_next;
  logic [7:0]            la_k;
  logic [LCNT_W-1:0]     k_inc;
  logic [HCNT_W-1:0]     win_cap;
  logic [HCNT_W-1:0]     win;
  logic [HIDX_W-1:0]     best_idx;
  logic                  is_m;
  logic [LCNT_W-1:0]     used;

  assign la_k  = la[k[LIDX_W-1:0]];
  assign k_inc = k + LCNT_W'(1);

  always_comb begin
    for (int j = 0; j < HIST_DEPTH; j++) begin
      eq[j] = (probe[j] == la_k);
    end
    alive_next = alive & eq;
  end

  // Effective window: the register, capped by the store and by what is held.
  always_comb begin
    if (32'(window_size) > HIST_DEPTH) begin
      win_cap = HCNT_W'(HIST_DEPTH);
    end else begin
      win_cap = HCNT_W'(window_size);
    end
    win = (win_cap > hist_cnt) ? hist_cnt : win_cap;
  end

  // The largest surviving offset wins a tie.
  always_comb begin
    best_idx = '0;
    for (int j = 0; j < HIST_DEPTH; j++) begin
      if (alive[j]) best_idx = HIDX_W'(j);
    end
  end

  assign is_m = (32'(mlen) > 32'(min_match));
  assign used = is_m ? mlen : LCNT_W'(1);

  assign status.la_full      = (la_cnt == LCNT_W'(MAX_MATCH));
  assign status.la_empty     = (la_cnt == '0);
  assign status.search_done  = (alive_next == '0) || (k_inc == la_cnt);
  assign status.consume_last = (rem == LCNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      la_cnt   <= '0;
      hist_cnt <= '0;
    end else begin
      if (cmd.push) begin
        la_cnt <= la_cnt + LCNT_W'(1);
      end else if (cmd.consume) begin
        la_cnt <= la_cnt - LCNT_W'(1);
        if (32'(hist_cnt) < HIST_DEPTH) hist_cnt <= hist_cnt + HCNT_W'(1);
      end else if (cmd.clear) begin
        la_cnt   <= '0;
        hist_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      la[la_cnt[LIDX_W-1:0]] <= item.data_byte;
    end
    if (cmd.consume) begin
      for (int i = 0; i < MAX_MATCH - 1; i++) la[i] <= la[i+1];
      hist[0] <= la[0];
      for (int j = 1; j < HIST_DEPTH; j++) hist[j] <= hist[j-1];
      rem <= rem - LCNT_W'(1);
    end
    if (cmd.start) begin
      for (int j = 0; j < HIST_DEPTH; j++) begin
        probe[j] <= hist[j];
        alive[j] <= (HCNT_W'(j + 1) <= win);
      end
      k    <= '0;
      mlen <= '0;
    end
    if (cmd.step) begin
      probe[0] <= la_k;
      for (int j = 1; j < HIST_DEPTH; j++) probe[j] <= probe[j-1];
      if (alive_next != '0) begin
        alive <= alive_next;
        mlen  <= k_inc;
      end
      k <= k_inc;
    end
    if (cmd.decide) begin
      rem                  <= used;
      token.is_match       <= is_m;
      token.literal        <= is_m ? 8'd0 : la[0];
      token.offset         <= is_m ? OFF_W'(best_idx) + OFF_W'(1) : '0;
      token.length         <= is_m ? LEN_W'(mlen) : '0;
      token.end_of_message <= cmd.flush && (used == la_cnt);
    end
  end

endmodule

### rtl/core/lz77c_ctrl.sv
// Controller of the LZ77 encoder: sequences push, search, decision and consume steps.
module lz77c_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   item_last,
  output logic                   token_valid,
  input  logic                   token_ready,
  input  lz77c_pkg::dp_status_t  status,
  output lz77c_pkg::dp_cmd_t     cmd
);
  import lz77c_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_SEARCH  = 3'd2;
  localparam logic [2:0] ST_DECIDE  = 3'd3;
  localparam logic [2:0] ST_CONSUME = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       flush;
  logic       slot_free;

  assign item_ready = (state == ST_IDLE);
  assign slot_free  = !token_valid || token_ready;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.flush   = flush;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.push   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (flush) begin
          if (status.la_empty) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.start  = 1'b1;
            state_next = ST_SEARCH;
          end
        end else if (status.la_full) begin
          cmd.start  = 1'b1;
          state_next = ST_SEARCH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (status.search_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (slot_free) begin
          cmd.decide = 1'b1;
          state_next = ST_CONSUME;
        end
      end
      ST_CONSUME: begin
        cmd.consume = 1'b1;
        if (status.consume_last) state_next = ST_CHECK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      flush       <= 1'b0;
      token_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && item_valid) flush <= item_last;
      if (cmd.decide) begin
        token_valid <= 1'b1;
      end else if (token_ready) begin
        token_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/lz77_greedy_compressor_unit.sv
// Top level of the greedy LZ77 encoder: configuration registers, controller and datapath.
//
// The block takes message bytes one per transfer and emits LZ77 tokens, a literal or an
// offset/length pair, greedily choosing the longest match (oldest start on a tie) found in
// a window of up to 64 earlier bytes, possibly running into the 16-byte lookahead. A byte
// that produces no token passes the transfer and the check state. When the lookahead fills,
// one token is produced; on a byte marked last, tokens follow one after another until the
// lookahead is empty. Each token passes a check state, a search over the lookahead bytes
// until the match stops or the lookahead ends, a decision that waits while the previous
// token is still held in the output register, and a consume step for each byte it uses.
// The search runs one lookahead byte per cycle across 64 parallel compare cells, and the
// consume step moves one byte per cycle from lookahead into the history shift line;
// together these set the rate. A new byte is taken only when the previous one has been
// fully processed, while a finished token may still wait in the output register. The last
// byte of a message flushes every remaining token, the final one flagged end_of_message,
// and clears the history for the next message.
// Registers: window_size at byte address 0 (reset 64), min_match at address 4 (reset 3).
// They should be written only while the block is idle.
module lz77_greedy_compressor_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  lz77c_pkg::item_t              item,
  output logic                          token_valid,
  input  logic                          token_ready,
  output lz77c_pkg::token_t             token,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lz77c_pkg::PADDR_W-1:0] paddr,
  input  logic [lz77c_pkg::PDATA_W-1:0] pwdata,
  output logic [lz77c_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import lz77c_pkg::*;

  logic [WIN_W-1:0]  window_size;
  logic [MINM_W-1:0] min_match;
  dp_cmd_t           cmd;
  dp_status_t        status;

  assign pready = 1'b1;

  // A write lands on the access cycle; the register is picked by the word address.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RST;
      min_match   <= MIN_MATCH_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_WINDOW_SIZE: window_size <= pwdata[WIN_W-1:0];
        REG_MIN_MATCH:   min_match   <= pwdata[MINM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WINDOW_SIZE: prdata = PDATA_W'(window_size);
      REG_MIN_MATCH:   prdata = PDATA_W'(min_match);
      default:         prdata = '0;
    endcase
  end

  lz77c_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item_last   (item.last),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .status      (status),
    .cmd         (cmd)
  );

  lz77c_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .item        (item),
    .window_size (window_size),
    .min_match   (min_match),
    .status      (status),
    .token       (token)
  );

endmodule

### rtl/core/lz77c_checker.sv
// Port-level checker for the LZ77 encoder and its bind to the top level.
module lz77c_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input logic                token_valid,
  input logic                token_ready,
  input lz77c_pkg::token_t   token,
  input logic                pready
);
  import lz77c_pkg::*;

  a_token_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=> token_valid && $stable(token))
    else $error("token changed or dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !token_valid && item_ready)
    else $error("block not idle after reset");

  a_no_take_after_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second byte taken before the first was processed");

  a_match_fields: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.is_match |-> token.offset != '0 && token.length != '0
      && token.literal == 8'd0)
    else $error("malformed match token");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind lz77_greedy_compressor_unit lz77c_checker u_lz77c_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_ready  (item_ready),
  .token_valid (token_valid),
  .token_ready (token_ready),
  .token       (token),
  .pready      (pready)
);

### tb/sv/lz77_greedy_compressor_unit_tb.sv
// Self-checking testbench for the greedy LZ77 encoder: random and directed messages vs a predictor.
module lz77_greedy_compressor_unit_tb;
  import lz77c_pkg::*;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  item_t item;
  logic token_valid;
  logic token_ready;
  token_t token;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  lz77_greedy_compressor_unit uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .token_valid(token_valid), .token_ready(token_ready), .token(token),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam int QUIET_LIMIT = 20000;

  // Predictor state, kept apart from the block's own copy.
  logic [7:0] hist_mem [HIST_DEPTH];
  int unsigned hist_fill;
  int unsigned hist_wr;
  logic [7:0] la_mem [MAX_MATCH];
  int unsigned la_fill;
  int unsigned win_cfg;
  int unsigned minm_cfg;

  // Bytes waiting for the driver and tokens waiting for the monitor.
  item_t byte_queue[$];
  token_t token_queue[$];

  int errors;
  int tokens_seen;
  int match_tokens;
  int messages_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  // Set at the rising edge when the current byte was taken.
  bit item_ready_seen;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] hist_back(int unsigned d);
    return hist_mem[(hist_wr + HIST_DEPTH - d) % HIST_DEPTH];
  endfunction

  // Emits one token for the lookahead head and moves its bytes into history.
  function automatic token_t encode_head(bit may_end);
    token_t t;
    int unsigned win;
    int unsigned avail;
    int unsigned best;
    int unsigned best_off;
    int unsigned k;
    int unsigned used;
    logic [7:0] src;
    win = win_cfg;
    if (win > HIST_DEPTH) win = HIST_DEPTH;
    if (win > hist_fill) win = hist_fill;
    avail = la_fill;
    best = 0;
    best_off = 0;
    // Scan from the oldest start so a tie keeps the largest offset.
    for (int unsigned off = win; off >= 1; off--) begin
      for (k = 0; k < avail; k++) begin
        src = (k < off) ? hist_back(off - k) : la_mem[k - off];
        if (src != la_mem[k]) break;
      end
      if (k > best) begin
        best = k;
        best_off = off;
      end
    end
    t = '0;
    if (best > minm_cfg) begin
      t.is_match = 1'b1;
      t.offset = best_off[OFF_W-1:0];
      t.length = best[LEN_W-1:0];
      used = best;
    end else begin
      t.literal = la_mem[0];
      used = 1;
    end
    for (int unsigned i = 0; i < used; i++) begin
      hist_mem[hist_wr] = la_mem[i];
      hist_wr = (hist_wr + 1) % HIST_DEPTH;
      if (hist_fill < HIST_DEPTH) hist_fill++;
    end
    for (int unsigned i = 0; i + used < la_fill; i++) la_mem[i] = la_mem[i + used];
    la_fill -= used;
    t.end_of_message = may_end && (la_fill == 0);
    return t;
  endfunction

  // Predicts the tokens that one accepted byte causes.
  task automatic predict_byte(item_t it);
    int n;
    n = 0;
    if (la_fill >= MAX_MATCH) begin
      token_queue.push_back(encode_head(1'b0));
      n++;
    end
    la_mem[la_fill] = it.data_byte;
    la_fill++;
    if (it.last) begin
      while (la_fill > 0 && n < MAX_MATCH) begin
        token_queue.push_back(encode_head(1'b1));
        n++;
      end
      hist_fill = 0;
      hist_wr = 0;
      la_fill = 0;
    end else if (la_fill >= MAX_MATCH && n == 0) begin
      token_queue.push_back(encode_head(1'b0));
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("token %0d: %s got %0d expected %0d", tokens_seen, what, got, want);
  endtask

  // Driver: one transfer at a time, payload held until it is accepted.
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready_seen) begin
      if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        item <= byte_queue.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
    token_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predicts on each byte transfer and checks each token transfer.
  always @(posedge clk) begin
    item_ready_seen <= !rst && item_valid && item_ready;
    if (!rst) begin
      if (item_valid && item_ready) begin
        predict_byte(item);
      end
      if (token_valid && token_ready) begin
        if (token_queue.size() == 0) begin
          errors++;
          $display("token %0d arrived with nothing expected", tokens_seen);
        end else begin
          token_t want;
          want = token_queue.pop_front();
          if (token.is_match !== want.is_match)
            report_mismatch("is_match", token.is_match, want.is_match);
          if (token.literal !== want.literal)
            report_mismatch("literal", token.literal, want.literal);
          if (token.offset !== want.offset)
            report_mismatch("offset", token.offset, want.offset);
          if (token.length !== want.length)
            report_mismatch("length", token.length, want.length);
          if (token.end_of_message !== want.end_of_message)
            report_mismatch("end_of_message", token.end_of_message, want.end_of_message);
          if (want.is_match) match_tokens++;
        end
        tokens_seen++;
      end
      // Watchdog: count cycles in which no transfer of either kind happens.
      if ((item_valid && item_ready) || (token_valid && token_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lz77_greedy_compressor_unit: mismatch");
      $finish;
    end
  end

  // APB write: setup cycle then access cycle; also mirrors into the predictor.
  task automatic write_reg(logic [0:0] idx, int unsigned value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_WINDOW_SIZE) win_cfg = value & 7'h7f;
    else minm_cfg = value & 5'h1f;
  endtask

  task automatic wait_idle();
    while (byte_queue.size() > 0 || item_valid || token_queue.size() > 0) @(posedge clk);
    // A byte that causes no token may still be in its check cycle.
    repeat (40) @(posedge clk);
  endtask

  task automatic add_message(int len, int alphabet);
    item_t it;
    for (int i = 0; i < len; i++) begin
      it.data_byte = (alphabet >= 256) ? 8'($urandom) : 8'($urandom_range(alphabet - 1));
      it.last = (i == len - 1);
      byte_queue.push_back(it);
    end
    messages_sent++;
  endtask

  // Repeats a random seed pattern so long matches and window edges get exercised.
  task automatic add_repeat_message(int len, int period);
    item_t it;
    logic [7:0] pat [64];
    for (int i = 0; i < period; i++) pat[i] = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      it.data_byte = ($urandom_range(15) == 0) ? 8'($urandom) : pat[i % period];
      it.last = (i == len - 1);
      byte_queue.push_back(it);
    end
    messages_sent++;
  endtask

  task automatic run_random(int n_bytes);
    int sent;
    int len;
    sent = 0;
    while (sent < n_bytes) begin
      len = $urandom_range(1, 60);
      case ($urandom_range(3))
        0: add_message(len, 256);
        1: add_message(len, 2);
        default: add_repeat_message(len, $urandom_range(1, 40));
      endcase
      sent += len;
    end
    wait_idle();
  endtask

  initial begin
    item_t it;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    token_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    tokens_seen = 0;
    match_tokens = 0;
    messages_sent = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hist_fill = 0;
    hist_wr = 0;
    la_fill = 0;
    win_cfg = WINDOW_SIZE_RST;
    minm_cfg = MIN_MATCH_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: single-byte message, extreme byte values, an all-equal run that
    // saturates at the longest match, and a long message that fills the lookahead.
    it.data_byte = 8'hff; it.last = 1'b1; byte_queue.push_back(it);
    it.data_byte = 8'h00; it.last = 1'b0; byte_queue.push_back(it);
    it.data_byte = 8'hff; it.last = 1'b1; byte_queue.push_back(it);
    for (int i = 0; i < 22; i++) begin
      it.data_byte = (i < 2) ? 8'h55 : 8'haa;
      it.last = (i == 21);
      byte_queue.push_back(it);
    end
    messages_sent += 3;
    wait_idle();

    // Window of zero and a minimum match no token can exceed: literals only.
    write_reg(REG_WINDOW_SIZE, 0);
    write_reg(REG_MIN_MATCH, 16);
    add_repeat_message(30, 3);
    wait_idle();
    // Window above the history depth and a minimum match of one.
    write_reg(REG_WINDOW_SIZE, 127);
    write_reg(REG_MIN_MATCH, 1);
    add_repeat_message(80, 5);
    wait_idle();

    // Random phases with varied register settings and idling.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_WINDOW_SIZE, (ph == 0) ? 1 : $urandom_range(1, 64));
      write_reg(REG_MIN_MATCH, (ph == 1) ? 31 : $urandom_range(1, 6));
      send_idle_pct = (ph == 1 || ph == 3) ? 64 : 0;
      recv_stall_pct = (ph == 2) ? 64 : 0;
      if (ph == 3) begin
        send_idle_pct = 17;
        recv_stall_pct = 17;
      end
      run_random(40);
    end
    write_reg(REG_WINDOW_SIZE, 64);
    write_reg(REG_MIN_MATCH, 3);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(15);

    $display("%0d messages encoded, %0d tokens checked, %0d of them matches", messages_sent,
             tokens_seen, match_tokens);
    if (errors == 0) begin
      $display("lz77_greedy_compressor_unit: match");
    end else begin
      $display("lz77_greedy_compressor_unit: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/lz77c_pkg.sv
rtl/core/lz77c_datapath.sv
rtl/core/lz77c_ctrl.sv
rtl/core/lz77_greedy_compressor_unit.sv
rtl/core/lz77c_checker.sv
tb/sv/lz77_greedy_compressor_unit_tb.sv
